// ===== src/qedr_pkg.sv =====
// Shared types, codes and constants of the quadrature encoder detent reader.
package qedr_pkg;

  localparam int VAL_W   = 16;   // width of value fields on the ports
  localparam int ITEMS_W = 15;
  localparam int STEP_W  = 12;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 5;
  localparam int BIG_W   = STEP_W + CFG_W;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_WRAP   = 2'd1,
    OP_CLAMP  = 2'd2,
    OP_FAST   = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DETENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 2'd1;

  localparam logic [CFG_W-1:0] DETENT_RST = 5'd4;
  localparam logic [CFG_W-1:0] FAST_RST   = 5'd10;

  // Transition code {previous A,B, new A,B}: bit set = count up / count down.
  localparam logic [15:0] CW_MASK  = 16'b0010_1000_0001_0100; // 1011 1101 0100 0010
  localparam logic [15:0] CCW_MASK = 16'b0100_0001_1000_0010; // 1000 1110 0111 0001

  localparam logic signed [CNT_W-1:0] CNT_MAX = 8'sd127;
  localparam logic signed [CNT_W-1:0] CNT_MIN = -8'sd127;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    clr;     // read consumed the count
  } step_res_t;

endpackage

// ===== src/qedr_step.sv =====
// Combinational read/step logic: wrap, clamp and fast/fine stepping.
module qedr_step #(
  parameter int VALUE_WIDTH = 16
) (
  input  qedr_pkg::op_t                              op,
  input  logic signed [qedr_pkg::VAL_W-1:0]          cur,
  input  logic [qedr_pkg::ITEMS_W-1:0]               items,
  input  logic [qedr_pkg::STEP_W-1:0]                step,
  input  logic [qedr_pkg::BIG_W-1:0]                 big,
  input  logic signed [qedr_pkg::VAL_W-1:0]          lo,
  input  logic signed [qedr_pkg::VAL_W-1:0]          hi,
  input  logic signed [qedr_pkg::CNT_W-1:0]          cnt,
  input  logic [qedr_pkg::CFG_W-1:0]                 det,
  output qedr_pkg::step_res_t                        res
);
  import qedr_pkg::*;

  localparam int SUM_W = BIG_W + 2;
  localparam int SAT_W = 34;
  localparam logic signed [SAT_W-1:0] SAT_HI = (34'sd1 <<< (VALUE_WIDTH - 1)) - 34'sd1;
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - 34'sd1;

  function automatic logic signed [VAL_W-1:0] clamp_lim(
    input logic signed [SUM_W-1:0] x,
    input logic signed [VAL_W-1:0] l,
    input logic signed [VAL_W-1:0] h
  );
    logic signed [SUM_W-1:0] lx;
    logic signed [SUM_W-1:0] hx;
    lx = SUM_W'(l);
    hx = SUM_W'(h);
    if (x < lx) return l;
    else if (x > hx) return h;
    else return x[VAL_W-1:0];
  endfunction

  logic signed [CNT_W:0]   cnt9;
  logic signed [CNT_W:0]   det9;
  logic                    ge_det;
  logic                    le_ndet;
  logic                    in_menu;
  logic [ITEMS_W-1:0]      c0;
  logic [ITEMS_W:0]        cp;
  logic [ITEMS_W-1:0]      wrap_up;
  logic [ITEMS_W-1:0]      wrap_dn;
  logic signed [SUM_W-1:0] cur_x;
  logic signed [SUM_W-1:0] step_x;
  logic signed [SUM_W-1:0] big_x;
  logic signed [VAL_W-1:0] pre;
  logic signed [SAT_W-1:0] pre_x;
  logic                    clr;

  assign cnt9    = (CNT_W+1)'(cnt);
  assign det9    = {{(CNT_W+1-CFG_W){1'b0}}, det};
  assign ge_det  = cnt9 >= det9;
  assign le_ndet = cnt9 <= -det9;

  // out-of-menu current is taken as zero before stepping
  assign in_menu = !cur[VAL_W-1] && (cur[ITEMS_W-1:0] < items);
  assign c0      = in_menu ? cur[ITEMS_W-1:0] : '0;
  assign cp      = {1'b0, c0} + (ITEMS_W+1)'(1);
  assign wrap_up = (cp >= {1'b0, items}) ? ITEMS_W'(cp - {1'b0, items}) : cp[ITEMS_W-1:0];
  assign wrap_dn = (c0 == '0) ? ITEMS_W'(items - ITEMS_W'(1)) : ITEMS_W'(c0 - ITEMS_W'(1));

  assign cur_x  = SUM_W'(cur);
  assign step_x = {{(SUM_W-STEP_W){1'b0}}, step};
  assign big_x  = {{(SUM_W-BIG_W){1'b0}}, big};

  always_comb begin
    pre = cur;
    clr = 1'b0;
    unique case (op)
      OP_SAMPLE: begin
        pre = '0;
      end
      OP_WRAP: begin
        if (ge_det || le_ndet) begin
          clr = 1'b1;
          if (items == '0) pre = '0;
          else if (ge_det) pre = VAL_W'({1'b0, wrap_up});
          else pre = VAL_W'({1'b0, wrap_dn});
        end
      end
      OP_CLAMP: begin
        if (ge_det) begin
          clr = 1'b1;
          pre = clamp_lim(cur_x + step_x, lo, hi);
        end else if (le_ndet) begin
          clr = 1'b1;
          pre = clamp_lim(cur_x - step_x, lo, hi);
        end
      end
      OP_FAST: begin
        clr = 1'b1;
        // a downward decision overrides an upward one
        if (le_ndet) pre = clamp_lim(cur_x - big_x, lo, hi);
        else if (cnt < 0) pre = clamp_lim(cur_x - step_x, lo, hi);
        else if (ge_det) pre = clamp_lim(cur_x + big_x, lo, hi);
        else if (cnt > 0) pre = clamp_lim(cur_x + step_x, lo, hi);
      end
      default: pre = '0;
    endcase
  end

  assign pre_x = SAT_W'(pre);

  always_comb begin
    res.clr = clr;
    if (pre_x > SAT_HI) res.value = VAL_W'(SAT_HI);
    else if (pre_x < SAT_LO) res.value = VAL_W'(SAT_LO);
    else res.value = pre;
  end

endmodule

// ===== src/qedr_tracker.sv =====
// Encoder state: last pin pair and saturating signed transition count.
module qedr_tracker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  qedr_pkg::op_t                      op,
  input  logic                               pin_a,
  input  logic                               pin_b,
  input  logic                               clr,
  output logic signed [qedr_pkg::CNT_W-1:0]  count,
  output logic signed [qedr_pkg::CNT_W-1:0]  count_nxt
);
  import qedr_pkg::*;

  logic [1:0]              last_pins_r;
  logic [1:0]              last_pins_nxt;
  logic signed [CNT_W-1:0] count_r;
  logic [3:0]              code;

  assign code = {last_pins_r, pin_a, pin_b};

  always_comb begin
    count_nxt     = count_r;
    last_pins_nxt = last_pins_r;
    if (op == OP_SAMPLE) begin
      last_pins_nxt = {pin_a, pin_b};
      if (CW_MASK[code] && count_r < CNT_MAX) count_nxt = count_r + 8'sd1;
      else if (CCW_MASK[code] && count_r > CNT_MIN) count_nxt = count_r - 8'sd1;
    end else if (clr) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pins_r <= '0;
      count_r     <= '0;
    end else if (fire) begin
      last_pins_r <= last_pins_nxt;
      count_r     <= count_nxt;
    end
  end

  assign count = count_r;

`ifndef SYNTHESIS
  a_pins_follow: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op == OP_SAMPLE |=> last_pins_r == $past({pin_a, pin_b}))
    else $error("last pins not updated by sample");
  a_fast_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op == OP_FAST |=> count_r == '0)
    else $error("fast read left count nonzero");
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r) && $stable(last_pins_r))
    else $error("state changed without an item");
`endif

endmodule

// ===== src/quadrature_encoder_detent_reader_core.sv =====
// Top level of the quadrature encoder detent reader: ports, registers, config.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser op, tdata pins/value/limits
//  out_    | out | out_tvalid/tready  | tdata new_value, count_now
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One item per cycle sustained while out_ accepts; each item passes the input
// register, then step logic and the encoder state into the result register.
// The transition count feedback closes within the step stage, so each item
// sees the count left by the one before it. Stalls on out_ back up through
// both registers. Reset (rst_n low, synchronous) clears the pipeline valids,
// the encoder state and restores the config defaults. cfg_ready is always high.
module quadrature_encoder_detent_reader_core #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [0] pin_a, [1] pin_b, [17:2] current_value, [32:18] item_count,
  // [44:33] step_size, [60:45] lower_limit, [76:61] upper_limit, [79:77] zero
  input  logic [qedr_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] op
  input  logic [1:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] new_value, [23:16] count_now
  output logic [qedr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qedr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qedr_pkg::CFG_W-1:0]           cfg_data
);
  import qedr_pkg::*;

  logic [CFG_W-1:0]        det_r;
  logic [CFG_W-1:0]        fast_r;

  logic                    s1_valid_r;
  op_t                     s1_op_r;
  logic                    s1_pin_a_r;
  logic                    s1_pin_b_r;
  logic signed [VAL_W-1:0] s1_cur_r;
  logic [ITEMS_W-1:0]      s1_items_r;
  logic [STEP_W-1:0]       s1_step_r;
  logic [BIG_W-1:0]        s1_big_r;
  logic signed [VAL_W-1:0] s1_lo_r;
  logic signed [VAL_W-1:0] s1_hi_r;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic signed [CNT_W-1:0] out_count_r;

  logic                    out_free;
  logic                    fire;
  logic                    in_fire;
  step_res_t               res;
  logic signed [CNT_W-1:0] count;
  logic signed [CNT_W-1:0] count_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r  <= DETENT_RST;
      fast_r <= FAST_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DETENT) det_r <= cfg_data;
      else if (cfg_index == CFG_FAST) fast_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // the fast step product is formed on entry, keeping the multiply off the clamp path
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= op_t'(in_tuser);
      s1_pin_a_r <= in_tdata[0];
      s1_pin_b_r <= in_tdata[1];
      s1_cur_r   <= in_tdata[17:2];
      s1_items_r <= in_tdata[32:18];
      s1_step_r  <= in_tdata[44:33];
      s1_big_r   <= BIG_W'(in_tdata[44:33]) * BIG_W'(fast_r);
      s1_lo_r    <= in_tdata[60:45];
      s1_hi_r    <= in_tdata[76:61];
    end
  end

  qedr_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .op    (s1_op_r),
    .cur   (s1_cur_r),
    .items (s1_items_r),
    .step  (s1_step_r),
    .big   (s1_big_r),
    .lo    (s1_lo_r),
    .hi    (s1_hi_r),
    .cnt   (count),
    .det   (det_r),
    .res   (res)
  );

  qedr_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .op        (s1_op_r),
    .pin_a     (s1_pin_a_r),
    .pin_b     (s1_pin_b_r),
    .clr       (res.clr),
    .count     (count),
    .count_nxt (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_value_r <= res.value;
      out_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_value_r};

endmodule
